// ----- design/kcc_pkg.sv -----
// Shared types, constants and helpers of the Japanese kanji code converter.
// Used by every module of the converter; depends on nothing.
`default_nettype none

package kcc_pkg;

   // Register indexes on the configuration port.
   localparam logic REG_INPUT_CODE  = 1'b0;
   localparam logic REG_OUTPUT_CODE = 1'b1;

   // Source encodings.
   localparam logic IN_SJIS = 1'b0;
   localparam logic IN_EUC  = 1'b1;

   // Target encodings.
   localparam logic [1:0] OUT_COPY = 2'd0;
   localparam logic [1:0] OUT_SJIS = 2'd1;
   localparam logic [1:0] OUT_EUC  = 2'd2;
   localparam logic [1:0] OUT_JIS7 = 2'd3;

   // Longest burst of bytes that one source byte can cause.
   localparam int MAX_OUT = 9;

   localparam logic [7:0] BYTE_SO        = 8'h0e;
   localparam logic [7:0] BYTE_SI        = 8'h0f;
   localparam logic [7:0] BYTE_ESC       = 8'h1b;
   localparam logic [7:0] BYTE_DOLLAR    = 8'h24;
   localparam logic [7:0] BYTE_LPAREN    = 8'h28;
   localparam logic [7:0] BYTE_B         = 8'h42;
   localparam logic [7:0] BYTE_KANA_PFX  = 8'h8e;
   localparam logic [15:0] GETA_CODE     = 16'h81ac;
   localparam logic [15:0] REMAP_START   = 16'hf000;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] base;
   } remap_type;

   // Vendor extension area of Shift-JIS folded back onto the standard area.
   localparam remap_type REMAP_TAB [0:15] = '{
      '{16'hfa40, 16'hfa49, 16'heeef}, '{16'hfa4a, 16'hfa53, 16'h8754},
      '{16'hfa54, 16'hfa54, 16'h81ca}, '{16'hfa55, 16'hfa57, 16'heefa},
      '{16'hfa58, 16'hfa58, 16'h878a}, '{16'hfa59, 16'hfa59, 16'h8782},
      '{16'hfa5a, 16'hfa5a, 16'h8784}, '{16'hfa5b, 16'hfa5b, 16'h81e6},
      '{16'hfa5c, 16'hfa7e, 16'hed40}, '{16'hfa80, 16'hfa9b, 16'hed63},
      '{16'hfa9c, 16'hfafc, 16'hed80}, '{16'hfb40, 16'hfb5b, 16'hede1},
      '{16'hfb5c, 16'hfb7e, 16'hee40}, '{16'hfb80, 16'hfb9b, 16'hee63},
      '{16'hfb9c, 16'hfbfc, 16'hee80}, '{16'hfc40, 16'hfc4b, 16'heee1}
   };

   // Converter state carried from one source byte to the next.
   typedef struct packed {
      logic [7:0] held_lead;
      logic       lead_waiting;
      logic       kana_prefix_waiting;
      logic       kana_mode;
      logic       kanji_mode;
   } state_type;

   // Status seen by the top level.
   typedef struct packed {
      state_type  st;
      logic [1:0] output_code;
   } status_type;

   // Bytes caused by one source byte; entry 0 goes out first.
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [3:0]              count;
   } burst_type;

   // Appends one byte to a burst.
   function automatic burst_type put(burst_type b, logic [7:0] v);
      burst_type r;
      r = b;
      if (b.count < 4'(MAX_OUT)) begin
         r.bytes[b.count] = v;
         r.count = b.count + 4'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/japanese_kanji_code_converter_unit.sv -----
// Top level of the Japanese kanji code converter.
// Uses kcc_pkg and instantiates kcc_conv and kcc_outq.
`default_nettype none

// The unit converts a byte stream in Shift-JIS or EUC-JP into Shift-JIS,
// EUC-JP, seven-bit JIS with SO/SI and ESC $ B / ESC ( B sequences, or
// passes it through unchanged; input_code (register 0) and output_code
// (register 1) select the pair and should be written only while the unit
// is idle, since every write also drops a held lead byte and returns to
// ascii mode. Each request word carries one source byte, with tlast marking
// the end of a string: on that word the unit closes any open kana or kanji
// mode and clears its state. A request word first lands in an input
// register; from there the whole conversion for that byte is done at once
// and its result bytes (zero to nine of them) go into a burst register
// when it can take them, which sends them one response word per cycle
// while rsp_tready is high, with tlast on the last byte caused by the source
// byte. Outside copy mode, a lead byte or an EUC kana prefix that does not
// end a string causes no response words. A request word is taken whenever
// the input register is empty or its byte moves on, which it does when the
// burst register is empty or is sending its last byte. A source byte gives
// one byte for ascii, one or two for kana (two when an EUC prefix or a
// shift-out is added), two for the second byte of a kanji pair, and up to nine
// when escape sequences are added. No clearing pass is needed after reset.

module japanese_kanji_code_converter_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // final_req
   // Response channel.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,   // run_last
   // Configuration port.
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [1:0] csr_wdata
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_final_ff;
   logic                step;
   logic                load_ok;
   kcc_pkg::burst_type  burst;
   kcc_pkg::status_type status;

   // The input register moves on whenever the burst register can take its result.
   assign step       = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_final_ff <= req_tlast;
      end
   end

   kcc_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .in_byte   (in_byte_ff),
      .in_final  (in_final_ff),
      .burst     (burst),
      .status    (status)
   );

   kcc_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .burst      (burst),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A held byte must not be taken over while the burst register is still busy.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load_ok) |-> !req_tready)
      else $error("request taken while input register is stuck");

   // A lead byte and a kana prefix are never held at the same time.
   a_one_held: assert property (@(posedge clock) disable iff (reset)
      !(status.st.lead_waiting && status.st.kana_prefix_waiting))
      else $error("lead and kana prefix both held");

   // Shift modes exist only for seven-bit JIS output.
   a_mode_jis7: assert property (@(posedge clock) disable iff (reset)
      (status.st.kana_mode || status.st.kanji_mode) |->
      (status.output_code == kcc_pkg::OUT_JIS7))
      else $error("shift mode open outside seven-bit JIS output");

   // The final byte of a string leaves no state behind.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (step && in_final_ff && !csr_we) |=> (status.st == '0))
      else $error("state left over after final byte");

endmodule

`default_nettype wire

// ----- design/kcc_sj2jis.sv -----
// Shift-JIS pair to seven-bit JIS row and column, with the extension remap.
// Uses kcc_pkg for the remap table and the GETA code.
`default_nettype none

module kcc_sj2jis (
   input  wire logic [7:0] lead,
   input  wire logic [7:0] trail,
   output logic      [7:0] row,
   output logic      [7:0] col
);

   always_comb begin
      logic [15:0] w;
      logic [15:0] nw;
      logic [7:0]  s1;
      logic [7:0]  s2;
      logic [8:0]  j1w;
      logic [7:0]  j1;
      logic [7:0]  j2;
      w  = {lead, trail};
      nw = w;
      if (w >= kcc_pkg::REMAP_START) begin
         // Ranges do not overlap, so at most one of them matches.
         nw = kcc_pkg::GETA_CODE;
         for (int i = 0; i < 16; i++) begin
            if (w >= kcc_pkg::REMAP_TAB[i].lo && w <= kcc_pkg::REMAP_TAB[i].hi) begin
               nw = w - kcc_pkg::REMAP_TAB[i].lo + kcc_pkg::REMAP_TAB[i].base;
            end
         end
      end
      s1  = nw[15:8];
      s2  = nw[7:0];
      j1w = {s1, 1'b0} - ((s1 <= 8'h9f) ? 9'h0e1 : 9'h161);
      j1  = j1w[7:0];
      if (s2 < 8'h9f) begin
         j2 = s2 - ((s2 > 8'h7f) ? 8'h20 : 8'h1f);
      end else begin
         j1 = j1 + 8'd1;
         j2 = s2 - 8'h7e;
      end
      row = j1;
      col = j2;
   end

endmodule

`default_nettype wire

// ----- design/kcc_conv.sv -----
// Configuration registers, converter state and the burst builder.
// Uses kcc_pkg and instantiates kcc_sj2jis.
`default_nettype none

module kcc_conv (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [1:0]             csr_wdata,
   input  wire logic                   step,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   in_final,
   output kcc_pkg::burst_type          burst,
   output kcc_pkg::status_type         status
);

   typedef struct packed {
      logic jis7;
      logic s2e;
      logic copy;
      logic src_euc;
   } mode_type;

   typedef struct packed {
      kcc_pkg::state_type st;
      kcc_pkg::burst_type bu;
   } work_type;

   logic                input_code_ff;
   logic [1:0]          output_code_ff;
   kcc_pkg::state_type  state_ff;
   kcc_pkg::state_type  state_in;
   mode_type            mode;
   logic [7:0]          jis_row;
   logic [7:0]          jis_cell;
   logic [7:0]          euc_s1;
   logic [7:0]          euc_s2;

   function automatic work_type close_kana(work_type w);
      work_type r;
      r = w;
      if (w.st.kana_mode) begin
         r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_SI);
      end
      r.st.kana_mode = 1'b0;
      return r;
   endfunction

   function automatic work_type close_kanji(work_type w);
      work_type r;
      r = w;
      if (w.st.kanji_mode) begin
         r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_ESC);
         r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_LPAREN);
         r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_B);
      end
      r.st.kanji_mode = 1'b0;
      return r;
   endfunction

   function automatic work_type emit_plain(work_type w, mode_type m, logic [7:0] v);
      work_type r;
      r = w;
      if (m.jis7) begin
         r = close_kana(r);
         r = close_kanji(r);
      end
      r.bu = kcc_pkg::put(r.bu, v);
      return r;
   endfunction

   function automatic work_type emit_kana(work_type w, mode_type m, logic [7:0] k);
      work_type r;
      r = w;
      if (m.jis7) begin
         if (!r.st.kana_mode) begin
            r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_SO);
         end
         r.st.kana_mode = 1'b1;
         r.bu = kcc_pkg::put(r.bu, {1'b0, k[6:0]});
      end else if (m.s2e) begin
         r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_KANA_PFX);
         r.bu = kcc_pkg::put(r.bu, k);
      end else begin
         r.bu = kcc_pkg::put(r.bu, k);
      end
      return r;
   endfunction

   function automatic work_type emit_pair(work_type w, mode_type m,
                                          logic [7:0] l, logic [7:0] t,
                                          logic [7:0] row, logic [7:0] col,
                                          logic [7:0] es1, logic [7:0] es2);
      work_type r;
      r = w;
      if (m.jis7) begin
         r = close_kana(r);
         if (!r.st.kanji_mode) begin
            r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_ESC);
            r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_DOLLAR);
            r.bu = kcc_pkg::put(r.bu, kcc_pkg::BYTE_B);
         end
         r.st.kanji_mode = 1'b1;
         if (!m.src_euc) begin
            r.bu = kcc_pkg::put(r.bu, row);
            r.bu = kcc_pkg::put(r.bu, col);
         end else begin
            r.bu = kcc_pkg::put(r.bu, {1'b0, l[6:0]});
            r.bu = kcc_pkg::put(r.bu, {1'b0, t[6:0]});
         end
      end else if (m.s2e) begin
         r.bu = kcc_pkg::put(r.bu, {1'b1, row[6:0]});
         r.bu = kcc_pkg::put(r.bu, {1'b1, col[6:0]});
      end else begin
         r.bu = kcc_pkg::put(r.bu, es1);
         r.bu = kcc_pkg::put(r.bu, es2);
      end
      return r;
   endfunction

   function automatic work_type fresh(work_type w, mode_type m, logic [7:0] b);
      work_type r;
      r = w;
      if (m.src_euc) begin
         if (b == kcc_pkg::BYTE_KANA_PFX) begin
            r.st.kana_prefix_waiting = 1'b1;
         end else if (b >= 8'ha1 && b <= 8'hfe) begin
            r.st.held_lead = b;
            r.st.lead_waiting = 1'b1;
         end else begin
            r = emit_plain(r, m, b);
         end
      end else begin
         if (b >= 8'ha1 && b <= 8'hdf) begin
            r = emit_kana(r, m, b);
         end else if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) begin
            r.st.held_lead = b;
            r.st.lead_waiting = 1'b1;
         end else begin
            r = emit_plain(r, m, b);
         end
      end
      return r;
   endfunction

   kcc_sj2jis u_sj2jis (
      .lead  (state_ff.held_lead),
      .trail (in_byte),
      .row   (jis_row),
      .col   (jis_cell)
   );

   always_comb begin
      mode.jis7    = (output_code_ff == kcc_pkg::OUT_JIS7);
      mode.s2e     = (output_code_ff == kcc_pkg::OUT_EUC) &&
                     (input_code_ff == kcc_pkg::IN_SJIS);
      mode.src_euc = (input_code_ff == kcc_pkg::IN_EUC);
      mode.copy    = !mode.jis7 && !mode.s2e &&
                     !((output_code_ff == kcc_pkg::OUT_SJIS) && mode.src_euc);
   end

   // EUC pair to Shift-JIS. Nine-bit math keeps the low byte exact.
   always_comb begin
      logic [8:0] j1;
      logic [7:0] j2;
      logic [8:0] half;
      j1     = {2'b00, state_ff.held_lead[6:0]};
      j2     = {1'b0, in_byte[6:0]};
      half   = (j1 - 9'd1) >> 1;
      euc_s1 = half[7:0] + ((j1 < 9'h05f) ? 8'h71 : 8'hb1);
      if (j1[0]) begin
         euc_s2 = j2 + ((j2 < 8'h60) ? 8'h1f : 8'h20);
      end else begin
         euc_s2 = j2 + 8'h7e;
      end
   end

   always_comb begin
      work_type w;
      w.st = state_ff;
      w.bu = '0;
      if (mode.copy) begin
         w.bu = kcc_pkg::put(w.bu, in_byte);
      end else if (state_ff.lead_waiting) begin
         w.st.lead_waiting = 1'b0;
         w = emit_pair(w, mode, state_ff.held_lead, in_byte, jis_row, jis_cell,
                       euc_s1, euc_s2);
         w.st.held_lead = 8'h00;
      end else if (state_ff.kana_prefix_waiting) begin
         w.st.kana_prefix_waiting = 1'b0;
         if (in_byte >= 8'ha1 && in_byte <= 8'hdf) begin
            w = emit_kana(w, mode, in_byte);
         end else begin
            w = emit_plain(w, mode, kcc_pkg::BYTE_KANA_PFX);
            w = fresh(w, mode, in_byte);
         end
      end else begin
         w = fresh(w, mode, in_byte);
      end
      if (in_final) begin
         // A dangling kana prefix goes out as a plain byte; a dangling lead is dropped.
         if (w.st.kana_prefix_waiting) begin
            w.st.kana_prefix_waiting = 1'b0;
            w = emit_plain(w, mode, kcc_pkg::BYTE_KANA_PFX);
         end
         if (mode.jis7) begin
            w = close_kana(w);
            w = close_kanji(w);
         end
         w.st = '0;
      end
      burst    = w.bu;
      state_in = w.st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_code_ff  <= kcc_pkg::IN_SJIS;
         output_code_ff <= kcc_pkg::OUT_COPY;
         state_ff       <= '0;
      end else if (csr_we) begin
         // Any register write drops held bytes and returns to ascii mode.
         state_ff <= '0;
         case (csr_index)
            kcc_pkg::REG_INPUT_CODE:  input_code_ff  <= csr_wdata[0];
            kcc_pkg::REG_OUTPUT_CODE: output_code_ff <= csr_wdata;
            default:                  input_code_ff  <= input_code_ff;
         endcase
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   assign status.st          = state_ff;
   assign status.output_code = output_code_ff;

endmodule

`default_nettype wire

// ----- design/kcc_outq.sv -----
// Result register of the converter: holds one burst and sends it a byte at a time.
// Uses kcc_pkg for the burst type.
`default_nettype none

module kcc_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  kcc_pkg::burst_type      burst,
   output logic                    load_ok,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);

   logic [kcc_pkg::MAX_OUT-1:0][7:0] bytes_ff;
   logic [kcc_pkg::MAX_OUT-1:0][7:0] bytes_in;
   logic [3:0]                       cnt_ff;
   logic [3:0]                       cnt_in;
   logic                             pop;

   assign pop     = (cnt_ff != 4'd0) && rsp_tready;
   assign load_ok = (cnt_ff == 4'd0) || ((cnt_ff == 4'd1) && rsp_tready);

   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         bytes_in = burst.bytes;
         cnt_in   = burst.count;
      end else if (pop) begin
         bytes_in = {8'h00, bytes_ff[kcc_pkg::MAX_OUT-1:1]};
         cnt_in   = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bytes_ff <= bytes_in;
   end

   assign rsp_tvalid = (cnt_ff != 4'd0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = (cnt_ff == 4'd1);

endmodule

`default_nettype wire

// ----- verif/tb_japanese_kanji_code_converter_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for japanese_kanji_code_converter_unit: converts text streams through
// every source/target encoding pair but Shift-JIS to copy and checks each response word in order.
// Depends on kcc_pkg and the converter RTL only.

module tb_japanese_kanji_code_converter_unit;

   // A source word or a converted word: one byte plus its tlast flag.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_word_type;

   // Which conversion path the current register pair selects.
   typedef enum logic [1:0] {
      ROUTE_COPY,
      ROUTE_SJIS_TO_EUC,
      ROUTE_EUC_TO_SJIS,
      ROUTE_JIS7
   } route_type;

   // One range of the vendor extension area and where it folds to.
   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] base;
   } vendor_span_type;

   localparam vendor_span_type VENDOR_SPANS [16] = '{
      '{16'hfa40, 16'hfa49, 16'heeef}, '{16'hfa4a, 16'hfa53, 16'h8754},
      '{16'hfa54, 16'hfa54, 16'h81ca}, '{16'hfa55, 16'hfa57, 16'heefa},
      '{16'hfa58, 16'hfa58, 16'h878a}, '{16'hfa59, 16'hfa59, 16'h8782},
      '{16'hfa5a, 16'hfa5a, 16'h8784}, '{16'hfa5b, 16'hfa5b, 16'h81e6},
      '{16'hfa5c, 16'hfa7e, 16'hed40}, '{16'hfa80, 16'hfa9b, 16'hed63},
      '{16'hfa9c, 16'hfafc, 16'hed80}, '{16'hfb40, 16'hfb5b, 16'hede1},
      '{16'hfb5c, 16'hfb7e, 16'hee40}, '{16'hfb80, 16'hfb9b, 16'hee63},
      '{16'hfb9c, 16'hfbfc, 16'hee80}, '{16'hfc40, 16'hfc4b, 16'heee1}
   };

   localparam logic [15:0] VENDOR_FLOOR = 16'hf000;
   localparam logic [15:0] GETA_MARK    = 16'h81ac;
   localparam logic [7:0]  SHIFT_OUT    = 8'h0e;
   localparam logic [7:0]  SHIFT_IN     = 8'h0f;
   localparam logic [7:0]  ESCAPE       = 8'h1b;
   localparam logic [7:0]  DOLLAR_SIGN  = 8'h24;
   localparam logic [7:0]  LEFT_PAREN   = 8'h28;
   localparam logic [7:0]  LETTER_B     = 8'h42;
   localparam logic [7:0]  KANA_PREFIX  = 8'h8e;
   localparam int          BURST_MAX    = 9;

   // Cycles allowed for a lead byte (which produces nothing) to settle in the
   // converter before a register write, and the quiet time at the end.
   localparam int SETTLE_CYCLES  = 6;
   // The run is declared hung after this many cycles without any handshake.
   localparam int WATCHDOG_LIMIT = 2000;

   // Random part: register pairs visited in order, one block of text each.
   localparam int  BLOCK_COUNT = 10;
   localparam int  BLOCK_WORDS = 42;
   localparam logic BLOCK_SRC [BLOCK_COUNT] = '{
      kcc_pkg::IN_SJIS, kcc_pkg::IN_EUC, kcc_pkg::IN_SJIS, kcc_pkg::IN_EUC,
      kcc_pkg::IN_EUC, kcc_pkg::IN_SJIS, kcc_pkg::IN_SJIS, kcc_pkg::IN_EUC,
      kcc_pkg::IN_EUC, kcc_pkg::IN_SJIS
   };
   localparam logic [1:0] BLOCK_DST [BLOCK_COUNT] = '{
      kcc_pkg::OUT_JIS7, kcc_pkg::OUT_SJIS, kcc_pkg::OUT_EUC, kcc_pkg::OUT_JIS7,
      kcc_pkg::OUT_COPY, kcc_pkg::OUT_JIS7, kcc_pkg::OUT_SJIS, kcc_pkg::OUT_JIS7,
      kcc_pkg::OUT_EUC, kcc_pkg::OUT_EUC
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_we;
   logic       csr_index;
   logic [1:0] csr_wdata;

   japanese_kanji_code_converter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Source words waiting for the driver, and converted words that the
   // converter still owes us, oldest first.
   text_word_type source_words [$];
   text_word_type expected_bytes [$];

   // Bytes produced by the source byte being converted right now.
   logic [7:0] burst_bytes [$];

   // Shadow copy of the converter's registers and conversion state.
   logic       source_code;
   route_type  route;
   logic [7:0] lead_byte;
   logic       lead_pending;
   logic       prefix_pending;
   logic       in_kana;
   logic       in_kanji;

   int  mismatch_count;
   int  stall_cycles;
   int  send_idle_pct;
   int  recv_idle_pct;
   // Set at a rising edge when the request word on the bus was taken, so the
   // driver knows at the following falling edge to present the next one.
   logic req_taken;

   // ------------------------------------------------------------------
   // Conversion predictor.
   // ------------------------------------------------------------------

   // Appends one byte to the current burst; a burst never exceeds nine.
   function automatic void emit(logic [7:0] b);
      if (burst_bytes.size() < BURST_MAX) burst_bytes.push_back(b);
   endfunction

   function automatic void close_kana();
      if (in_kana) emit(SHIFT_IN);
      in_kana = 1'b0;
   endfunction

   function automatic void close_kanji();
      if (in_kanji) begin
         emit(ESCAPE);
         emit(LEFT_PAREN);
         emit(LETTER_B);
      end
      in_kanji = 1'b0;
   endfunction

   // Shift-JIS pair to the 7-bit JIS row and column, after folding the vendor
   // extension area back onto standard codes (anything unmapped becomes geta).
   function automatic logic [15:0] sjis_to_jis_cell(logic [7:0] lead, logic [7:0] trail);
      logic [15:0] orig;
      logic [15:0] code;
      logic [31:0] s1;
      logic [31:0] s2;
      logic [31:0] j1;
      logic [31:0] j2;
      int          i;
      orig = {lead, trail};
      code = orig;
      if (orig >= VENDOR_FLOOR) begin
         code = GETA_MARK;
         for (i = 0; i < 16; i++) begin
            if (orig >= VENDOR_SPANS[i].lo && orig <= VENDOR_SPANS[i].hi)
               code = orig - VENDOR_SPANS[i].lo + VENDOR_SPANS[i].base;
         end
      end
      s1 = {24'd0, code[15:8]};
      s2 = {24'd0, code[7:0]};
      j1 = s1 * 2 - ((s1 <= 32'h9f) ? 32'he1 : 32'h161);
      if (s2 < 32'h9f) begin
         j2 = s2 - ((s2 > 32'h7f) ? 32'h20 : 32'h1f);
      end else begin
         j1 = j1 + 1;
         j2 = s2 - 32'h7e;
      end
      return {j1[7:0], j2[7:0]};
   endfunction

   // An ascii or unclassified byte; in JIS7 it first drops back to ascii.
   function automatic void emit_plain(logic [7:0] b);
      if (route == ROUTE_JIS7) begin
         close_kana();
         close_kanji();
      end
      emit(b);
   endfunction

   function automatic void emit_kana(logic [7:0] k);
      case (route)
         ROUTE_JIS7: begin
            // Kana may open inside kanji mode without closing it.
            if (!in_kana) emit(SHIFT_OUT);
            in_kana = 1'b1;
            emit({1'b0, k[6:0]});
         end
         ROUTE_SJIS_TO_EUC: begin
            emit(KANA_PREFIX);
            emit(k);
         end
         default: emit(k);
      endcase
   endfunction

   function automatic void emit_pair(logic [7:0] lead, logic [7:0] trail);
      logic [15:0] pair_code;
      logic [7:0]  j1;
      logic [7:0]  j2;
      logic [7:0]  s1;
      logic [7:0]  s2;
      case (route)
         ROUTE_JIS7: begin
            close_kana();
            if (!in_kanji) begin
               emit(ESCAPE);
               emit(DOLLAR_SIGN);
               emit(LETTER_B);
            end
            in_kanji = 1'b1;
            if (source_code == kcc_pkg::IN_SJIS) begin
               pair_code = sjis_to_jis_cell(lead, trail);
               emit(pair_code[15:8]);
               emit(pair_code[7:0]);
            end else begin
               emit({1'b0, lead[6:0]});
               emit({1'b0, trail[6:0]});
            end
         end
         ROUTE_SJIS_TO_EUC: begin
            pair_code = sjis_to_jis_cell(lead, trail);
            emit(pair_code[15:8] | 8'h80);
            emit(pair_code[7:0] | 8'h80);
         end
         default: begin
            // EUC to Shift-JIS: odd rows take the lower trail range.
            j1 = {1'b0, lead[6:0]};
            j2 = {1'b0, trail[6:0]};
            s1 = ((j1 - 8'd1) >> 1) + ((j1 < 8'h5f) ? 8'h71 : 8'hb1);
            if (j1[0]) s2 = j2 + ((j2 < 8'h60) ? 8'h1f : 8'h20);
            else s2 = j2 + 8'h7e;
            emit(s1);
            emit(s2);
         end
      endcase
   endfunction

   // A byte seen with nothing held: classify it by the source encoding.
   function automatic void take_fresh(logic [7:0] b);
      if (source_code == kcc_pkg::IN_EUC) begin
         if (b == KANA_PREFIX) begin
            prefix_pending = 1'b1;
         end else if (b >= 8'ha1 && b <= 8'hfe) begin
            lead_byte = b;
            lead_pending = 1'b1;
         end else begin
            emit_plain(b);
         end
      end else begin
         if (b >= 8'ha1 && b <= 8'hdf) begin
            emit_kana(b);
         end else if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) begin
            lead_byte = b;
            lead_pending = 1'b1;
         end else begin
            emit_plain(b);
         end
      end
   endfunction

   function automatic void clear_shadow_state();
      lead_byte = 8'h00;
      lead_pending = 1'b0;
      prefix_pending = 1'b0;
      in_kana = 1'b0;
      in_kanji = 1'b0;
   endfunction

   // Works out every response word that one accepted source word causes and
   // queues them, with tlast on the last one.
   function automatic void convert_source_byte(logic [7:0] b, logic final_word);
      text_word_type w;
      int            n;
      burst_bytes.delete();
      if (route == ROUTE_COPY) begin
         emit(b);
      end else if (lead_pending) begin
         lead_pending = 1'b0;
         emit_pair(lead_byte, b);
         lead_byte = 8'h00;
      end else if (prefix_pending) begin
         prefix_pending = 1'b0;
         if (b >= 8'ha1 && b <= 8'hdf) begin
            emit_kana(b);
         end else begin
            // A prefix without kana behind it is an ordinary byte.
            emit_plain(KANA_PREFIX);
            take_fresh(b);
         end
      end else begin
         take_fresh(b);
      end

      if (final_word) begin
         // A dangling prefix goes out as itself; a dangling lead is lost.
         if (prefix_pending) begin
            prefix_pending = 1'b0;
            emit_plain(KANA_PREFIX);
         end
         if (route == ROUTE_JIS7) begin
            close_kana();
            close_kanji();
         end
         clear_shadow_state();
      end

      n = burst_bytes.size();
      for (int i = 0; i < n; i++) begin
         w.data = burst_bytes[i];
         w.last = (i == n - 1);
         expected_bytes.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------
   // Clock, driver and monitor.
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The driver presents source words at the falling edge. A word stays on
   // the bus until it is taken; between words the sender may idle.
   always @(negedge clock) begin : drive_words
      text_word_type next_word;
      logic          send_now;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            send_now = source_words.size() != 0 &&
                       $urandom_range(99) >= send_idle_pct;
            if (send_now) begin
               next_word = source_words.pop_front();
               req_tdata <= next_word.data;
               req_tlast <= next_word.last;
            end
            req_tvalid <= send_now;
         end
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // The monitor samples both channels at the rising edge. Responses are
   // checked before the new source word is predicted; a source word cannot
   // cause a response in the same cycle it is taken, so the order is safe.
   always @(posedge clock) begin : watch_words
      text_word_type want;
      logic          req_fire;
      logic          rsp_fire;
      if (reset) begin
         req_taken <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_fire = req_tvalid && req_tready;
         rsp_fire = rsp_tvalid && rsp_tready;
         req_taken <= req_fire;

         if (rsp_fire) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected response word: expected none, got byte %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %h, got %h",
                           $time, want.data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: run_last mismatch: expected %b, got %b",
                           $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end

         if (req_fire) convert_source_byte(req_tdata, req_tlast);

         // Watchdog: any handshake proves the converter is still alive.
         if (req_fire || rsp_fire) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   task automatic queue_word(logic [7:0] b, logic final_word);
      text_word_type w;
      w.data = b;
      w.last = final_word;
      source_words.push_back(w);
   endtask

   // Returns once every source word is taken and every response has come,
   // then lets a lead byte still in flight settle.
   task automatic wait_until_drained();
      while (source_words.size() != 0 || req_tvalid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both code registers while the converter is idle and mirrors the
   // write in the shadow state; every write drops held bytes and modes.
   task automatic write_codes(logic src, logic [1:0] dst);
      wait_until_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= kcc_pkg::REG_INPUT_CODE;
      csr_wdata <= {1'b0, src};
      @(negedge clock);
      csr_index <= kcc_pkg::REG_OUTPUT_CODE;
      csr_wdata <= dst;
      @(negedge clock);
      csr_we <= 1'b0;
      source_code = src;
      if (dst == kcc_pkg::OUT_JIS7) route = ROUTE_JIS7;
      else if (dst == kcc_pkg::OUT_SJIS && src == kcc_pkg::IN_EUC) route = ROUTE_EUC_TO_SJIS;
      else if (dst == kcc_pkg::OUT_EUC && src == kcc_pkg::IN_SJIS) route = ROUTE_SJIS_TO_EUC;
      else route = ROUTE_COPY;
      clear_shadow_state();
   endtask

   // Random text shaped after the current source encoding: mostly well-formed
   // ascii, kana and kanji, with noise bytes, broken prefixes and leads cut off
   // by a final word mixed in.
   task automatic queue_random_text(int count);
      int         made;
      int         pick;
      logic       fin;
      logic [7:0] lead;
      logic [7:0] trail;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         fin  = ($urandom_range(7) == 0);
         if (pick < 25) begin
            queue_word(8'($urandom_range(8'h7f)), fin);
            made += 1;
         end else if (pick < 45) begin
            if (source_code == kcc_pkg::IN_EUC) begin
               queue_word(KANA_PREFIX, 1'b0);
               made += 1;
            end
            queue_word(8'($urandom_range(8'hdf, 8'ha1)), fin);
            made += 1;
         end else if (pick < 85) begin
            if (source_code == kcc_pkg::IN_EUC) begin
               lead = 8'($urandom_range(8'hfe, 8'ha1));
            end else begin
               case ($urandom_range(3))
                  0:       lead = 8'($urandom_range(8'h9f, 8'h81));
                  1:       lead = 8'($urandom_range(8'hef, 8'he0));
                  2:       lead = 8'($urandom_range(8'hfc, 8'hfa));
                  default: lead = 8'($urandom_range(8'hfc, 8'hf0));
               endcase
            end
            if ($urandom_range(9) == 0) trail = 8'($urandom_range(8'hff));
            else if (source_code == kcc_pkg::IN_EUC) trail = 8'($urandom_range(8'hfe, 8'ha1));
            else trail = 8'($urandom_range(8'hfc, 8'h40));
            // Now and then the string ends right on the lead.
            queue_word(lead, $urandom_range(15) == 0);
            queue_word(trail, fin);
            made += 2;
         end else if (pick < 92 && source_code == kcc_pkg::IN_EUC) begin
            // Kana prefix followed by a random byte, which need not be kana.
            queue_word(KANA_PREFIX, $urandom_range(5) == 0);
            queue_word(8'($urandom_range(8'hff)), fin);
            made += 2;
         end else begin
            queue_word(8'($urandom_range(8'hff)), fin);
            made += 1;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_index      = kcc_pkg::REG_INPUT_CODE;
      csr_wdata      = 2'd0;
      mismatch_count = 0;
      source_code    = kcc_pkg::IN_SJIS;
      route          = ROUTE_COPY;
      clear_shadow_state();
      send_idle_pct  = 29;
      recv_idle_pct  = 63;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Shift-JIS to JIS7: ascii, kana run, kanji pair, vendor remap, a code
      // in no remap range (geta), the largest lead with an odd trail, kana
      // opened inside kanji mode, and a lead left dangling on the final word.
      write_codes(kcc_pkg::IN_SJIS, kcc_pkg::OUT_JIS7);
      queue_word(8'h41, 1'b0);
      queue_word(8'hb1, 1'b0);
      queue_word(8'hb2, 1'b0);
      queue_word(8'h88, 1'b0);
      queue_word(8'h9f, 1'b0);
      queue_word(8'hfa, 1'b0);
      queue_word(8'h40, 1'b0);
      queue_word(8'hf0, 1'b0);
      queue_word(8'h40, 1'b0);
      queue_word(8'hfc, 1'b0);
      queue_word(8'hff, 1'b0);
      queue_word(8'hb3, 1'b0);
      queue_word(8'he0, 1'b1);

      // EUC to JIS7: kana, a prefix without kana, a kanji pair in the highest row
      // and a prefix left dangling on the final word.
      write_codes(kcc_pkg::IN_EUC, kcc_pkg::OUT_JIS7);
      queue_word(KANA_PREFIX, 1'b0);
      queue_word(8'hb1, 1'b0);
      queue_word(KANA_PREFIX, 1'b0);
      queue_word(8'h41, 1'b0);
      queue_word(8'hfe, 1'b0);
      queue_word(8'ha1, 1'b0);
      queue_word(KANA_PREFIX, 1'b1);

      // EUC to Shift-JIS: lowest pair, then a plain top byte ending the string.
      write_codes(kcc_pkg::IN_EUC, kcc_pkg::OUT_SJIS);
      queue_word(8'ha1, 1'b0);
      queue_word(8'ha1, 1'b0);
      queue_word(8'hff, 1'b1);

      // Shift-JIS to EUC: kana gains its prefix, out-of-range trail after a lead.
      write_codes(kcc_pkg::IN_SJIS, kcc_pkg::OUT_EUC);
      queue_word(8'hdf, 1'b0);
      queue_word(8'h9f, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'h80, 1'b1);

      // Copy mode passes everything through and holds nothing.
      write_codes(kcc_pkg::IN_EUC, kcc_pkg::OUT_COPY);
      queue_word(KANA_PREFIX, 1'b0);
      queue_word(8'hfe, 1'b1);

      // Random blocks: both sides idle first one way, then the other, then
      // the last blocks run at full speed.
      for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
         write_codes(BLOCK_SRC[blk], BLOCK_DST[blk]);
         if (blk == 4) begin
            send_idle_pct = 63;
            recv_idle_pct = 29;
         end else if (blk == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_text(BLOCK_WORDS);
      end

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
